[rtl/dpcn_pkg.sv]
// Shared constants, codes and word types of the debounced pin change notifier.
`default_nettype none

package dpcn_pkg;

    localparam int PORTS       = 3;
    localparam int SUBSCRIBERS = 8;
    localparam int PIN_WIDTH   = 8;

    localparam int PORT_W = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int SLOT_W = (SUBSCRIBERS > 1) ? $clog2(SUBSCRIBERS) : 1;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_ENABLE  = 2'd1,
        OP_DISABLE = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ALREADY_ON  = 2'd1,
        ST_ALREADY_OFF = 2'd2,
        ST_BAD_PORT    = 2'd3
    } t_status;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_NOTIFY = 1'b1
    } t_kind;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] pins0;
        logic [7:0] pins1;
        logic [7:0] pins2;
        logic [2:0] slot;
        logic [1:0] port;
        logic [7:0] mask;
        logic [7:0] event_code;
    } t_in_word;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [2:0] target_slot;
        logic [1:0] changed_port;
        logic [7:0] event_out;
        logic [7:0] level;
        logic [7:0] changed;
        logic       last;
    } t_out_word;

    // port bank control
    typedef struct packed {
        logic                 deb_en;
        logic                 mask_or_en;
        logic                 mask_set_en;
        logic [PORT_W-1:0]    idx;
        logic [PIN_WIDTH-1:0] raw;
        logic [PIN_WIDTH-1:0] mask;
    } t_bank_cmd;

    typedef struct packed {
        logic [PIN_WIDTH-1:0] toggled;
        logic [PIN_WIDTH-1:0] level;
    } t_bank_resp;

    // slot table control
    typedef struct packed {
        logic                 set_en;
        logic                 clr_en;
        logic [SLOT_W-1:0]    idx;
        logic [PORT_W-1:0]    port;
        logic [PIN_WIDTH-1:0] pins;
        logic [7:0]           event_code;
    } t_slot_cmd;

    typedef struct packed {
        logic                 active;
        logic [PORT_W-1:0]    port;
        logic [PIN_WIDTH-1:0] pins;
        logic [7:0]           event_code;
    } t_slot_entry;

endpackage

`default_nettype wire

[rtl/dpcn_channels.sv]
// Valid/ready channel interfaces for input and result words.
`default_nettype none

interface dpcn_in_if;
    import dpcn_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dpcn_out_if;
    import dpcn_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/dpcn_port_bank.sv]
// Per-port debounce counters, stable levels and watch masks with one access port.
`default_nettype none

module dpcn_port_bank (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  dpcn_pkg::t_bank_cmd   i_cmd,
    output dpcn_pkg::t_bank_resp  o_resp
);
    import dpcn_pkg::*;

    logic [PIN_WIDTH-1:0] r_stable [PORTS];
    logic [PIN_WIDTH-1:0] r_cnt_lo [PORTS];
    logic [PIN_WIDTH-1:0] r_cnt_hi [PORTS];
    logic [PIN_WIDTH-1:0] r_watch  [PORTS];

    logic                 idx_ok;
    logic [PIN_WIDTH-1:0] cur_stable, cur_lo, cur_hi, cur_watch;
    logic [PIN_WIDTH-1:0] sample, delta, n_lo, n_hi, toggled;

    assign idx_ok = (int'(i_cmd.idx) < PORTS);

    always_comb begin
        cur_stable = '0;
        cur_lo     = '0;
        cur_hi     = '0;
        cur_watch  = '0;
        if (idx_ok) begin
            cur_stable = r_stable[i_cmd.idx];
            cur_lo     = r_cnt_lo[i_cmd.idx];
            cur_hi     = r_cnt_hi[i_cmd.idx];
            cur_watch  = r_watch[i_cmd.idx];
        end
    end

    // 2-bit vertical counter: counts identical differing samples per pin
    assign sample  = i_cmd.raw & cur_watch;
    assign delta   = cur_stable ^ sample;
    assign n_hi    = (cur_hi ^ cur_lo) & delta;
    assign n_lo    = ~cur_lo & delta;
    assign toggled = delta & ~(n_hi | n_lo);

    assign o_resp.toggled = toggled;
    assign o_resp.level   = cur_stable ^ toggled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORTS; p++) begin
                r_stable[p] <= '0;
                r_cnt_lo[p] <= '0;
                r_cnt_hi[p] <= '0;
                r_watch[p]  <= '0;
            end
        end else if (idx_ok) begin
            if (i_cmd.deb_en) begin
                r_stable[i_cmd.idx] <= cur_stable ^ toggled;
                r_cnt_lo[i_cmd.idx] <= n_lo;
                r_cnt_hi[i_cmd.idx] <= n_hi;
            end
            if (i_cmd.mask_or_en) begin
                r_watch[i_cmd.idx] <= cur_watch | i_cmd.mask;
            end else if (i_cmd.mask_set_en) begin
                r_watch[i_cmd.idx] <= i_cmd.mask;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/dpcn_slot_table.sv]
// Subscriber slot table: active flags plus stored port, pin mask and event.
`default_nettype none

module dpcn_slot_table (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  dpcn_pkg::t_slot_cmd    i_cmd,
    output dpcn_pkg::t_slot_entry  o_entry
);
    import dpcn_pkg::*;

    logic                 r_active [SUBSCRIBERS];
    logic [PORT_W-1:0]    r_port   [SUBSCRIBERS];
    logic [PIN_WIDTH-1:0] r_pins   [SUBSCRIBERS];
    logic [7:0]           r_event  [SUBSCRIBERS];

    assign o_entry.active     = r_active[i_cmd.idx];
    assign o_entry.port       = r_port[i_cmd.idx];
    assign o_entry.pins       = r_pins[i_cmd.idx];
    assign o_entry.event_code = r_event[i_cmd.idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SUBSCRIBERS; s++) begin
                r_active[s] <= 1'b0;
            end
        end else if (i_cmd.set_en) begin
            r_active[i_cmd.idx] <= 1'b1;
        end else if (i_cmd.clr_en) begin
            r_active[i_cmd.idx] <= 1'b0;
        end
    end

    // stored fields are only read while the slot is active
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_en) begin
            r_port[i_cmd.idx]  <= i_cmd.port;
            r_pins[i_cmd.idx]  <= i_cmd.pins;
            r_event[i_cmd.idx] <= i_cmd.event_code;
        end
    end

endmodule

`default_nettype wire

[rtl/debounced_pin_change_notifier_unit.sv]
// Top level: sequencer, result staging and output register of the pin change notifier.
//
// Usage: words arrive on i_in (valid/ready). A tick word carries raw samples of
// three 8-pin ports; enable/disable words add or remove a subscriber slot.
// Results leave on o_out (valid/ready) from an output register.
// The block takes one word at a time: i_in.ready is high only while idle.
// Tick: the word is accepted, each port is debounced in turn, all slots are
// scanned for each port whose debounced level changed, then a finish step.
// One match unit tests one slot per cycle unless a receiver stall holds the scan.
// Notifications are staged one deep so the final one can carry last; each is
// released when the next match shows up or the scan ends.
// Enable: one status word. Disable: the status word, then the port's watch
// mask is rebuilt one slot per cycle.
// Receiver stall: the sequencer holds wherever it must hand over a word and the
// output register is still full; nothing is lost or repeated.
// Reset (synchronous, active low): debounce state, watch masks, active flags
// and all control clear; stored slot fields are left as they are.
`default_nettype none

module debounced_pin_change_notifier_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dpcn_in_if.sink     i_in,
    dpcn_out_if.source  o_out
);
    import dpcn_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEB,
        S_SCAN,
        S_FIN,
        S_CFG,
        S_MSCAN
    } t_state;

    localparam logic [PORT_W-1:0] LAST_PORT = PORT_W'(PORTS - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SUBSCRIBERS - 1);

    t_state               r_state, n_state;
    t_in_word             r_in, n_in;
    logic [PORT_W-1:0]    r_p, n_p;
    logic [SLOT_W-1:0]    r_s, n_s;
    logic [PORT_W-1:0]    r_port, n_port;
    logic [PIN_WIDTH-1:0] r_tog, n_tog;
    logic [PIN_WIDTH-1:0] r_lvl, n_lvl;
    logic [PIN_WIDTH-1:0] r_acc, n_acc;
    logic                 r_have_pend, n_have_pend;
    t_out_word            r_pend, n_pend;
    logic                 r_ov, n_ov;
    t_out_word            r_out, n_out;

    t_bank_cmd            bank_cmd;
    t_bank_resp           bank_resp;
    t_slot_cmd            slot_cmd;
    t_slot_entry          ent;

    logic                 out_free;
    logic                 push;
    t_out_word            push_word;
    logic                 match;
    t_out_word            cand;
    logic [1:0]           status;
    logic [PIN_WIDTH-1:0] raw;
    logic [PIN_WIDTH-1:0] acc_next;

    dpcn_port_bank u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (bank_cmd),
        .o_resp  (bank_resp)
    );

    dpcn_slot_table u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (slot_cmd),
        .o_entry (ent)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;
    assign out_free    = !r_ov || o_out.ready;

    // raw samples of the port under debounce; ports past the pin fields read 0
    always_comb begin
        raw = '0;
        case (r_p)
            PORT_W'(0): raw = PIN_WIDTH'(r_in.pins0);
            PORT_W'(1): raw = PIN_WIDTH'(r_in.pins1);
            PORT_W'(2): raw = PIN_WIDTH'(r_in.pins2);
            default:    raw = '0;
        endcase
    end

    // shared match unit: one slot against the current port's toggles
    assign match = ent.active && (ent.port == r_p) && ((ent.pins & r_tog) != '0);

    always_comb begin
        cand              = '0;
        cand.kind         = KIND_NOTIFY;
        cand.status       = ST_OK;
        cand.target_slot  = 3'(r_s);
        cand.changed_port = 2'(r_p);
        cand.event_out    = 8'(ent.event_code);
        cand.level        = 8'(r_lvl);
        cand.changed      = 8'(r_tog);
        cand.last         = 1'b0;
    end

    assign acc_next = (ent.active && (ent.port == r_port)) ? (r_acc | ent.pins) : r_acc;

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_p         = r_p;
        n_s         = r_s;
        n_port      = r_port;
        n_tog       = r_tog;
        n_lvl       = r_lvl;
        n_acc       = r_acc;
        n_have_pend = r_have_pend;
        n_pend      = r_pend;
        push        = 1'b0;
        push_word   = r_pend;
        status      = ST_OK;

        bank_cmd        = '0;
        bank_cmd.idx    = (r_state == S_DEB) ? r_p : r_port;
        bank_cmd.raw    = raw;
        bank_cmd.mask   = PIN_WIDTH'(r_in.mask);

        slot_cmd            = '0;
        slot_cmd.idx        = (r_state == S_CFG) ? SLOT_W'(r_in.slot) : r_s;
        slot_cmd.port       = r_port;
        slot_cmd.pins       = PIN_WIDTH'(r_in.mask);
        slot_cmd.event_code = r_in.event_code;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_in = i_in.data;
                    case (i_in.data.opcode)
                        OP_TICK: begin
                            n_state     = S_DEB;
                            n_p         = '0;
                            n_have_pend = 1'b0;
                        end
                        OP_ENABLE, OP_DISABLE: begin
                            n_state = S_CFG;
                            n_port  = PORT_W'(i_in.data.port);
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_DEB: begin
                bank_cmd.deb_en = 1'b1;
                n_tog           = bank_resp.toggled;
                n_lvl           = bank_resp.level;
                n_s             = '0;
                if (bank_resp.toggled != '0) begin
                    n_state = S_SCAN;
                end else if (r_p == LAST_PORT) begin
                    n_state = S_FIN;
                end else begin
                    n_p = r_p + PORT_W'(1);
                end
            end

            S_SCAN: begin
                // a second match releases the staged one, so it needs the register
                if (!(match && r_have_pend && !out_free)) begin
                    if (match) begin
                        push        = r_have_pend;
                        n_pend      = cand;
                        n_have_pend = 1'b1;
                    end
                    if (r_s == LAST_SLOT) begin
                        if (r_p == LAST_PORT) begin
                            n_state = S_FIN;
                        end else begin
                            n_p     = r_p + PORT_W'(1);
                            n_state = S_DEB;
                        end
                    end else begin
                        n_s = r_s + SLOT_W'(1);
                    end
                end
            end

            S_FIN: begin
                if (!r_have_pend) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    push           = 1'b1;
                    push_word.last = 1'b1;
                    n_have_pend    = 1'b0;
                    n_state        = S_IDLE;
                end
            end

            S_CFG: begin
                if (int'(r_in.slot) >= SUBSCRIBERS) begin
                    status = ST_BAD_PORT;
                end else if (r_in.opcode == OP_ENABLE) begin
                    if (int'(r_in.port) >= PORTS) begin
                        status = ST_BAD_PORT;
                    end else if (ent.active) begin
                        status = ST_ALREADY_ON;
                    end
                end else if (!ent.active) begin
                    status = ST_ALREADY_OFF;
                end

                push_word             = '0;
                push_word.kind        = KIND_STATUS;
                push_word.status      = status;
                push_word.target_slot = r_in.slot;
                push_word.last        = 1'b1;

                if (out_free) begin
                    push    = 1'b1;
                    n_state = S_IDLE;
                    if (status == ST_OK) begin
                        if (r_in.opcode == OP_ENABLE) begin
                            slot_cmd.set_en     = 1'b1;
                            bank_cmd.mask_or_en = 1'b1;
                        end else begin
                            slot_cmd.clr_en = 1'b1;
                            n_port          = ent.port;
                            n_acc           = '0;
                            n_s             = '0;
                            n_state         = S_MSCAN;
                        end
                    end
                end
            end

            S_MSCAN: begin
                // rebuild the watch mask from the remaining slots on that port
                n_acc = acc_next;
                if (r_s == LAST_SLOT) begin
                    bank_cmd.mask_set_en = 1'b1;
                    bank_cmd.mask        = acc_next;
                    n_state              = S_IDLE;
                end else begin
                    n_s = r_s + SLOT_W'(1);
                end
            end

            default: n_state = S_IDLE;
        endcase

        n_ov  = r_ov;
        n_out = r_out;
        if (push) begin
            n_ov  = 1'b1;
            n_out = push_word;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_pend <= 1'b0;
            r_ov        <= 1'b0;
            r_p         <= '0;
            r_s         <= '0;
        end else begin
            r_state     <= n_state;
            r_have_pend <= n_have_pend;
            r_ov        <= n_ov;
            r_p         <= n_p;
            r_s         <= n_s;
        end
        r_in   <= n_in;
        r_port <= n_port;
        r_tog  <= n_tog;
        r_lvl  <= n_lvl;
        r_acc  <= n_acc;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result word pushed into a full output register");

    a_idle_no_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_have_pend)
        else $error("staged notification left behind at idle");

    a_scan_has_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_tog != '0))
        else $error("slot scan entered for a port with no toggled pins");

    a_staged_is_notify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_pend |-> (r_pend.kind == KIND_NOTIFY))
        else $error("staged word is not a notification");

    a_cfg_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready &&
         (i_in.data.opcode == OP_ENABLE || i_in.data.opcode == OP_DISABLE))
        |=> (r_state == S_CFG))
        else $error("enable or disable word did not reach the status step");

endmodule

`default_nettype wire

[tb/dpcn_result_checker.sv]
// Result checker: mirrors the notifier state from accepted words and checks every result word.
module dpcn_result_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  dpcn_pkg::t_in_word  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  dpcn_pkg::t_out_word i_out_data,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_notifies
);
    timeunit 1ns;
    timeprecision 1ps;
    import dpcn_pkg::*;

    localparam int MAX_REPORTS = 40;

    // mirrored port bank and slot table
    logic [PIN_WIDTH-1:0] lvl_q      [PORTS];
    logic [PIN_WIDTH-1:0] vc_lo      [PORTS];
    logic [PIN_WIDTH-1:0] vc_hi      [PORTS];
    logic [PIN_WIDTH-1:0] port_watch [PORTS];
    logic                 sub_on     [SUBSCRIBERS];
    logic [PORT_W-1:0]    sub_port   [SUBSCRIBERS];
    logic [PIN_WIDTH-1:0] sub_mask   [SUBSCRIBERS];
    logic [7:0]           sub_event  [SUBSCRIBERS];

    t_out_word results_owed [$];
    t_out_word want;
    int        n_err;
    int        n_checked;
    int        n_notify;

    function automatic string show(input t_out_word r);
        return $sformatf("{kind=%0d st=%0d slot=%0d port=%0d ev=%02h lvl=%02h chg=%02h last=%0d}",
                         r.kind, r.status, r.target_slot, r.changed_port, r.event_out,
                         r.level, r.changed, r.last);
    endfunction

    // one tick: vertical-counter debounce per port, then notify matching slots
    task automatic follow_tick(input t_in_word w);
        logic [PIN_WIDTH-1:0] raw;
        logic [PIN_WIDTH-1:0] sample;
        logic [PIN_WIDTH-1:0] delta;
        logic [PIN_WIDTH-1:0] flips;
        t_out_word            r;
        t_out_word            tail;
        int                   made;
        made = 0;
        for (int p = 0; p < PORTS; p++) begin
            case (p)
                0:       raw = w.pins0;
                1:       raw = w.pins1;
                2:       raw = w.pins2;
                default: raw = '0;
            endcase
            sample   = raw & port_watch[p];
            delta    = lvl_q[p] ^ sample;
            vc_hi[p] = (vc_hi[p] ^ vc_lo[p]) & delta;
            vc_lo[p] = ~vc_lo[p] & delta;
            flips    = delta & ~(vc_hi[p] | vc_lo[p]);
            if (flips != '0) begin
                lvl_q[p] = lvl_q[p] ^ flips;
                for (int s = 0; s < SUBSCRIBERS; s++) begin
                    if (sub_on[s] && sub_port[s] == p && (sub_mask[s] & flips) != '0) begin
                        r              = '0;
                        r.kind         = KIND_NOTIFY;
                        r.status       = ST_OK;
                        r.target_slot  = SLOT_W'(s);
                        r.changed_port = PORT_W'(p);
                        r.event_out    = sub_event[s];
                        r.level        = lvl_q[p];
                        r.changed      = flips;
                        results_owed.push_back(r);
                        made++;
                    end
                end
            end
        end
        // final notification of the tick carries last
        if (made > 0) begin
            tail      = results_owed.pop_back();
            tail.last = 1'b1;
            results_owed.push_back(tail);
        end
    endtask

    task automatic follow_word(input t_in_word w);
        t_out_word            r;
        logic [PIN_WIDTH-1:0] rebuilt;
        logic [PORT_W-1:0]    sp;
        r = '0;
        r.kind        = KIND_STATUS;
        r.status      = ST_OK;
        r.target_slot = w.slot;
        r.last        = 1'b1;
        case (w.opcode)
            OP_TICK: begin
                follow_tick(w);
            end
            OP_ENABLE: begin
                // bad port is checked ahead of a double enable
                if (w.port >= PORTS) begin
                    r.status = ST_BAD_PORT;
                end else if (sub_on[w.slot]) begin
                    r.status = ST_ALREADY_ON;
                end else begin
                    sub_on[w.slot]     = 1'b1;
                    sub_port[w.slot]   = w.port;
                    sub_mask[w.slot]   = w.mask;
                    sub_event[w.slot]  = w.event_code;
                    port_watch[w.port] = port_watch[w.port] | w.mask;
                end
                results_owed.push_back(r);
            end
            OP_DISABLE: begin
                if (!sub_on[w.slot]) begin
                    r.status = ST_ALREADY_OFF;
                end else begin
                    sp             = sub_port[w.slot];
                    sub_on[w.slot] = 1'b0;
                    rebuilt        = '0;
                    for (int s = 0; s < SUBSCRIBERS; s++)
                        if (sub_on[s] && sub_port[s] == sp)
                            rebuilt = rebuilt | sub_mask[s];
                    port_watch[sp] = rebuilt;
                end
                results_owed.push_back(r);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORTS; p++) begin
                lvl_q[p]      = '0;
                vc_lo[p]      = '0;
                vc_hi[p]      = '0;
                port_watch[p] = '0;
            end
            for (int s = 0; s < SUBSCRIBERS; s++) begin
                sub_on[s]    = 1'b0;
                sub_port[s]  = '0;
                sub_mask[s]  = '0;
                sub_event[s] = '0;
            end
            results_owed.delete();
            n_err     = 0;
            n_checked = 0;
            n_notify  = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                follow_word(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (results_owed.size() == 0) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("%0t ns: result word with nothing owed, expected none, actual %s",
                                 $time, show(i_out_data));
                end else begin
                    want = results_owed.pop_front();
                    n_checked++;
                    if (want.kind == KIND_NOTIFY)
                        n_notify++;
                    if (i_out_data !== want) begin
                        n_err++;
                        if (n_err <= MAX_REPORTS)
                            $display("%0t ns: result mismatch, expected %s, actual %s",
                                     $time, show(want), show(i_out_data));
                    end
                end
            end
        end
        o_errors   <= n_err;
        o_pending  <= results_owed.size();
        o_checked  <= n_checked;
        o_notifies <= n_notify;
    end

endmodule

[tb/tb_top.sv]
// Testbench top: clock, reset, stimulus words, receiver stalls and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dpcn_pkg::*;

    localparam int RANDOM_WORDS = 390;
    // slowest run: the busy time plus up to 24 results per word, each behind a
    // receiver stall; the limit leaves ample margin
    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam int DRAIN_CYCLES = 64;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dpcn_in_if  in_ch  ();
    dpcn_out_if out_ch ();

    int errors;
    int pending;
    int checked;
    int notifies;

    debounced_pin_change_notifier_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dpcn_result_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_data   (in_ch.data),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_data  (out_ch.data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_notifies  (notifies)
    );

    always #2 clk = ~clk;

    // run watchdog
    int cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles, %0d result words still owed",
                     $time, cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver: random stalls, with stretches of none
    int rx_stall  = 0;
    bit rx_steady = 1'b0;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (cycles % 300 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            if (rx_stall > 0) begin
                rx_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 30)
                    rx_stall = idle_len();
            end
        end
    end

    // sender bookkeeping
    int n_sent  = 0;
    int n_tick  = 0;
    int n_en    = 0;
    int n_dis   = 0;
    int n_ign   = 0;
    bit tx_busy = 1'b0;

    task automatic push_word(input t_in_word w);
        int gap;
        in_ch.data  <= w;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        case (w.opcode)
            OP_TICK:    n_tick++;
            OP_ENABLE:  n_en++;
            OP_DISABLE: n_dis++;
            default:    n_ign++;
        endcase
        n_sent++;
        if (n_sent % 40 == 0)
            tx_busy = ($urandom_range(0, 3) == 0);
        gap = (tx_busy || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // all fields random, so unused fields still wiggle every bit
    function automatic t_in_word noise_word();
        t_in_word w;
        w = t_in_word'({$urandom, $urandom});
        return w;
    endfunction

    function automatic t_in_word tick_word(input logic [7:0] p0, p1, p2);
        t_in_word w;
        w        = noise_word();
        w.opcode = OP_TICK;
        w.pins0  = p0;
        w.pins1  = p1;
        w.pins2  = p2;
        return w;
    endfunction

    function automatic t_in_word sub_word(input t_opcode op, input logic [2:0] slot,
                                          input logic [1:0] port,
                                          input logic [7:0] mask, ev);
        t_in_word w;
        w            = noise_word();
        w.opcode     = op;
        w.slot       = slot;
        w.port       = port;
        w.mask       = mask;
        w.event_code = ev;
        return w;
    endfunction

    initial begin
        t_in_word   w;
        logic [7:0] pat0, pat1, pat2;
        int         r;
        int         burst;
        int         n_real;

        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening
        push_word(tick_word(8'h00, 8'h00, 8'h00));                   // quiet, nothing watched
        push_word(sub_word(OP_DISABLE, 3'd0, 2'd0, 8'h00, 8'h00));   // already off
        push_word(sub_word(OP_ENABLE, 3'd0, 2'd3, 8'hFF, 8'h77));    // bad port
        push_word(sub_word(OP_ENABLE, 3'd0, 2'd0, 8'hFF, 8'h00));
        push_word(sub_word(OP_ENABLE, 3'd0, 2'd1, 8'h01, 8'h11));    // already on
        push_word(sub_word(OP_ENABLE, 3'd7, 2'd2, 8'h80, 8'hFF));
        push_word(sub_word(OP_ENABLE, 3'd3, 2'd1, 8'h0F, 8'hA5));
        w = noise_word();
        w.opcode = OP_NONE;
        push_word(w);                                                 // unused opcode
        repeat (4) push_word(tick_word(8'hFF, 8'hFF, 8'hFF));        // flips on the 4th
        push_word(sub_word(OP_ENABLE, 3'd5, 2'd0, 8'h00, 8'h5A));    // empty mask
        repeat (4) push_word(tick_word(8'h00, 8'h00, 8'h00));        // back to zero
        push_word(sub_word(OP_DISABLE, 3'd0, 2'd0, 8'h00, 8'h00));
        push_word(sub_word(OP_DISABLE, 3'd0, 2'd0, 8'h00, 8'h00));   // already off
        push_word(sub_word(OP_DISABLE, 3'd3, 2'd2, 8'hFF, 8'hFF));

        // random part: mostly steady tick bursts so the debouncer settles,
        // mixed with subscriber churn, noise ticks and unused opcodes
        pat0   = 8'($urandom);
        pat1   = 8'($urandom);
        pat2   = 8'($urandom);
        n_real = 0;
        while (n_real < RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                w = noise_word();
                w.opcode = OP_NONE;
                push_word(w);
            end else if (r < 36) begin
                w = noise_word();
                w.opcode = ($urandom_range(0, 99) < 60) ? OP_ENABLE : OP_DISABLE;
                w.port   = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                case ($urandom_range(0, 4))
                    0:       w.mask = 8'(1 << $urandom_range(0, 7));
                    1:       w.mask = 8'hFF;
                    2:       w.mask = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
                    default: w.mask = 8'($urandom);
                endcase
                push_word(w);
                n_real++;
            end else begin
                if ($urandom_range(0, 1) == 0) pat0 = 8'($urandom);
                if ($urandom_range(0, 1) == 0) pat1 = 8'($urandom);
                if ($urandom_range(0, 2) == 0) pat2 = pat2 ^ 8'(1 << $urandom_range(0, 7));
                else if ($urandom_range(0, 1) == 0) pat2 = 8'($urandom);
                burst = $urandom_range(1, 6);
                for (int k = 0; k < burst; k++) begin
                    w = tick_word(pat0, pat1, pat2);
                    // occasional glitch restarts the count on one pin
                    if ($urandom_range(0, 9) == 0)
                        w.pins0 = w.pins0 ^ 8'(1 << $urandom_range(0, 7));
                    if ($urandom_range(0, 9) == 0)
                        w.pins1 = w.pins1 ^ 8'(1 << $urandom_range(0, 7));
                    push_word(w);
                    n_real++;
                end
            end
        end
        in_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d ticks, %0d enables, %0d disables and %0d ignored words.",
                 n_tick, n_en, n_dis, n_ign);
        $display("Checked %0d result words, %0d of them change notifications.",
                 checked, notifies);
        if (pending != 0)
            $display("%0t ns: %0d owed result words never arrived", $time, pending);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
